FILE: design/suv_pkg.sv
// shared types, constants and the arctangent table for the spherical texel address unit
package suv_pkg;

  localparam int MAX_TEXTURES_DEF = 4;
  localparam int MAX_TEX_DIM_DEF  = 4096;
  localparam int ANGLE_STAGES_DEF = 16;

  localparam int CNT_W   = 3;
  localparam int DIM_W   = 13;
  localparam int PITCH_W = 15;
  localparam int CFG_W   = 15;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_TEXTURE_COUNT = 2'd0;
  localparam logic [IDX_W-1:0] REG_TEX_WIDTH     = 2'd1;
  localparam logic [IDX_W-1:0] REG_TEX_HEIGHT    = 2'd2;
  localparam logic [IDX_W-1:0] REG_ROW_PITCH     = 2'd3;

  localparam int PRESCALE  = 8;
  localparam int CW        = 27;
  localparam int AW        = 35;
  localparam int SQ_STAGES = 4;
  localparam int SQ_STEPS  = 4;
  localparam int OFF_W     = 26;

  typedef struct packed {
    logic       use_tex;
    logic [1:0] sel;
    logic       uzero;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } suv_side_t;

  typedef struct packed {
    logic signed [CW-1:0] ux;
    logic signed [CW-1:0] uy;
    logic signed [AW-1:0] ua;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic signed [AW-1:0] va;
  } suv_vec_t;

  function automatic logic signed [AW-1:0] atan_of(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000517;
      20: v = 32'h0000028B;
      21: v = 32'h00000145;
      22: v = 32'h000000A2;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return AW'(signed'({1'b0, v}));
  endfunction

endpackage

FILE: design/suv_cordic_stage.sv
// one registered vectoring cordic stage, u and v angles side by side
module suv_cordic_stage
  import suv_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  input  suv_side_t in_side,
  input  suv_vec_t  in_vec,
  output logic      out_vld,
  output suv_side_t out_side,
  output suv_vec_t  out_vec
);

  logic      vld_r;
  suv_side_t side_r;
  suv_vec_t  vec_r;
  suv_vec_t  vec_nxt;

  always_comb begin
    vec_nxt = in_vec;
    if (in_vec.uy >= 0) begin
      vec_nxt.ux = in_vec.ux + (in_vec.uy >>> STAGE);
      vec_nxt.uy = in_vec.uy - (in_vec.ux >>> STAGE);
      vec_nxt.ua = in_vec.ua + atan_of(STAGE);
    end else begin
      vec_nxt.ux = in_vec.ux - (in_vec.uy >>> STAGE);
      vec_nxt.uy = in_vec.uy + (in_vec.ux >>> STAGE);
      vec_nxt.ua = in_vec.ua - atan_of(STAGE);
    end
    if (in_vec.vy >= 0) begin
      vec_nxt.vx = in_vec.vx + (in_vec.vy >>> STAGE);
      vec_nxt.vy = in_vec.vy - (in_vec.vx >>> STAGE);
      vec_nxt.va = in_vec.va + atan_of(STAGE);
    end else begin
      vec_nxt.vx = in_vec.vx - (in_vec.vy >>> STAGE);
      vec_nxt.vy = in_vec.vy + (in_vec.vx >>> STAGE);
      vec_nxt.va = in_vec.va - atan_of(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    side_r <= in_side;
    vec_r  <= vec_nxt;
  end

  assign out_vld  = vld_r;
  assign out_side = side_r;
  assign out_vec  = vec_r;

endmodule

FILE: design/spherical_uv_texel_address.sv
// top level: spherical uv texel address pipeline
//
// Usage: drive start with one word of normal, sphere flag, texture index and base
// colour; busy is always low, so a word is taken on every cycle with start high.
// Each word gives one result word, shown for one cycle with out_valid high.
// The pipeline is one input stage with the y*y product, four square root
// stages of four steps each, one cordic stage per angle stage, two texel
// scaling stages and the byte offset stage.
// Throughput is one word per cycle; every stage is a register, nothing iterates.
// Configuration: cfg_we writes register cfg_index (texture count, width, height,
// row pitch) with cfg_data; write only while no word is in flight.
// Reset (synchronous, rst_n low) clears all stage valid bits and sets the
// registers to count 0, size 1 by 1, pitch 4. Words in flight are dropped.
// The receiver cannot stall; results appear on out_valid whether taken or not.
// Fallback words carry the base colour with zero address fields; textured
// words carry the address with zero colour.
module spherical_uv_texel_address
  import suv_pkg::*;
#(
  parameter int MAX_TEXTURES = MAX_TEXTURES_DEF,
  parameter int MAX_TEX_DIM  = MAX_TEX_DIM_DEF,
  parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic               in_is_sphere,
  input  logic signed [3:0]  in_texture_index,
  input  logic [7:0]         in_base_red,
  input  logic [7:0]         in_base_green,
  input  logic [7:0]         in_base_blue,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output logic               out_valid,
  output logic               out_use_texture,
  output logic [1:0]         out_selected_texture,
  output logic [11:0]        out_texel_x,
  output logic [11:0]        out_texel_y,
  output logic [25:0]        out_texel_offset,
  output logic [7:0]         out_color_red,
  output logic [7:0]         out_color_green,
  output logic [7:0]         out_color_blue
);

  localparam int DW = $clog2(MAX_TEX_DIM + 1);

  // configuration
  logic [CNT_W-1:0]   tex_count_r;
  logic [DIM_W-1:0]   tex_width_r;
  logic [DIM_W-1:0]   tex_height_r;
  logic [PITCH_W-1:0] row_pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_count_r  <= '0;
      tex_width_r  <= DIM_W'(1);
      tex_height_r <= DIM_W'(1);
      row_pitch_r  <= PITCH_W'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEXTURE_COUNT: tex_count_r  <= cfg_data[CNT_W-1:0];
        REG_TEX_WIDTH:     tex_width_r  <= cfg_data[DIM_W-1:0];
        REG_TEX_HEIGHT:    tex_height_r <= cfg_data[DIM_W-1:0];
        REG_ROW_PITCH:     row_pitch_r  <= cfg_data[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0] dim_w;
  logic [DW-1:0] dim_h;
  int            cnt_sat;

  always_comb begin
    if (tex_width_r == '0) begin
      dim_w = DW'(1);
    end else if (32'(tex_width_r) > MAX_TEX_DIM) begin
      dim_w = DW'(MAX_TEX_DIM);
    end else begin
      dim_w = DW'(tex_width_r);
    end
    if (tex_height_r == '0) begin
      dim_h = DW'(1);
    end else if (32'(tex_height_r) > MAX_TEX_DIM) begin
      dim_h = DW'(MAX_TEX_DIM);
    end else begin
      dim_h = DW'(tex_height_r);
    end
    cnt_sat = (int'(tex_count_r) > MAX_TEXTURES) ? MAX_TEXTURES : int'(tex_count_r);
  end

  assign busy = 1'b0;

  // input stage
  logic signed [31:0] ny_sq;
  logic signed [32:0] rem_full;
  suv_side_t          side_in;

  always_comb begin
    ny_sq    = in_normal_y * in_normal_y;
    rem_full = 33'sd1073741824 - 33'(ny_sq);
    side_in.use_tex = in_is_sphere && !in_texture_index[3]
                      && (int'(in_texture_index[2:0]) < cnt_sat);
    side_in.sel     = in_texture_index[1:0];
    side_in.uzero   = (in_normal_x == '0) && (in_normal_z == '0);
    side_in.red     = in_base_red;
    side_in.green   = in_base_green;
    side_in.blue    = in_base_blue;
  end

  logic               sq_vld_r  [0:SQ_STAGES];
  suv_side_t          sq_side_r [0:SQ_STAGES];
  logic signed [15:0] sq_nx_r   [0:SQ_STAGES];
  logic signed [15:0] sq_ny_r   [0:SQ_STAGES];
  logic signed [15:0] sq_nz_r   [0:SQ_STAGES];
  logic [31:0]        sq_n_r    [0:SQ_STAGES];
  logic [31:0]        sq_root_r [0:SQ_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else begin
      sq_vld_r[0] <= start;
    end
    sq_side_r[0] <= side_in;
    sq_nx_r[0]   <= in_normal_x;
    sq_ny_r[0]   <= in_normal_y;
    sq_nz_r[0]   <= in_normal_z;
    sq_n_r[0]    <= (rem_full > 0) ? rem_full[31:0] : 32'd0;
    sq_root_r[0] <= '0;
  end

  // square root, four digit steps per stage
  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sq
    logic [31:0] n_nxt;
    logic [31:0] root_nxt;

    always_comb begin
      logic [31:0] bitv;
      n_nxt    = sq_n_r[s];
      root_nxt = sq_root_r[s];
      for (int k = 0; k < SQ_STEPS; k++) begin
        bitv = 32'd1 << (30 - 2 * (s * SQ_STEPS + k));
        if (n_nxt >= root_nxt + bitv) begin
          n_nxt    = n_nxt - (root_nxt + bitv);
          root_nxt = (root_nxt >> 1) + bitv;
        end else begin
          root_nxt = root_nxt >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[s+1] <= 1'b0;
      end else begin
        sq_vld_r[s+1] <= sq_vld_r[s];
      end
      sq_side_r[s+1] <= sq_side_r[s];
      sq_nx_r[s+1]   <= sq_nx_r[s];
      sq_ny_r[s+1]   <= sq_ny_r[s];
      sq_nz_r[s+1]   <= sq_nz_r[s];
      sq_n_r[s+1]    <= n_nxt;
      sq_root_r[s+1] <= root_nxt;
    end
  end

  // cordic chain
  logic      c_vld  [0:ANGLE_STAGES];
  suv_side_t c_side [0:ANGLE_STAGES];
  suv_vec_t  c_vec  [0:ANGLE_STAGES];

  always_comb begin
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] zs;
    xs = CW'(sq_nx_r[SQ_STAGES]) <<< PRESCALE;
    zs = CW'(sq_nz_r[SQ_STAGES]) <<< PRESCALE;
    c_vld[0]  = sq_vld_r[SQ_STAGES];
    c_side[0] = sq_side_r[SQ_STAGES];
    if (sq_nx_r[SQ_STAGES] < 0) begin
      c_vec[0].ux = -xs;
      c_vec[0].uy = -zs;
      c_vec[0].ua = (sq_nz_r[SQ_STAGES] >= 0) ? (AW'(1) <<< 31) : -(AW'(1) <<< 31);
    end else begin
      c_vec[0].ux = xs;
      c_vec[0].uy = zs;
      c_vec[0].ua = '0;
    end
    c_vec[0].vx = CW'(signed'({1'b0, sq_root_r[SQ_STAGES][16:0]})) <<< PRESCALE;
    c_vec[0].vy = CW'(sq_ny_r[SQ_STAGES]) <<< PRESCALE;
    c_vec[0].va = '0;
  end

  for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_cordic
    suv_cordic_stage #(.STAGE(i)) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (c_vld[i]),
      .in_side  (c_side[i]),
      .in_vec   (c_vec[i]),
      .out_vld  (c_vld[i+1]),
      .out_side (c_side[i+1]),
      .out_vec  (c_vec[i+1])
    );
  end

  // texel scaling
  logic signed [AW+1:0] uf_full;
  logic signed [AW+1:0] vf_full;
  logic [32:0]          uf;
  logic [32:0]          vf;
  logic [32+DW:0]       u_prod;
  logic [32+DW:0]       v_prod;

  always_comb begin
    uf_full = (c_side[ANGLE_STAGES].uzero ? '0 : (AW+2)'(c_vec[ANGLE_STAGES].ua))
              + ((AW+2)'(1) <<< 31);
    vf_full = ((AW+2)'(1) <<< 31) - ((AW+2)'(c_vec[ANGLE_STAGES].va) <<< 1);
    if (uf_full < 0) begin
      uf = '0;
    end else if (uf_full > ((AW+2)'(1) <<< 32)) begin
      uf = 33'h1_0000_0000;
    end else begin
      uf = uf_full[32:0];
    end
    if (vf_full < 0) begin
      vf = '0;
    end else if (vf_full > ((AW+2)'(1) <<< 32)) begin
      vf = 33'h1_0000_0000;
    end else begin
      vf = vf_full[32:0];
    end
    u_prod = (33 + DW)'(uf) * (33 + DW)'(dim_w);
    v_prod = (33 + DW)'(vf) * (33 + DW)'(dim_h);
  end

  logic      f1_vld_r;
  suv_side_t f1_side_r;
  logic [DW:0] f1_tx_r;
  logic [DW:0] f1_ty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= c_vld[ANGLE_STAGES];
    end
    f1_side_r <= c_side[ANGLE_STAGES];
    f1_tx_r   <= u_prod[32+DW:32];
    f1_ty_r   <= v_prod[32+DW:32];
  end

  logic [DW:0] w_last;
  logic [DW:0] h_last;

  assign w_last = (DW + 1)'(dim_w) - (DW + 1)'(1);
  assign h_last = (DW + 1)'(dim_h) - (DW + 1)'(1);

  logic          f2_vld_r;
  suv_side_t     f2_side_r;
  logic [DW-1:0] f2_tx_r;
  logic [DW-1:0] f2_ty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else begin
      f2_vld_r <= f1_vld_r;
    end
    f2_side_r <= f1_side_r;
    f2_tx_r   <= DW'((f1_tx_r > w_last) ? w_last : f1_tx_r);
    f2_ty_r   <= DW'((f1_ty_r > h_last) ? h_last : f1_ty_r);
  end

  // byte offset and result word
  logic [OFF_W-1:0] off_nxt;

  assign off_nxt = OFF_W'(32'(f2_ty_r) * 32'(row_pitch_r) + (32'(f2_tx_r) << 2));

  logic             out_vld_r;
  logic             out_use_r;
  logic [1:0]       out_sel_r;
  logic [11:0]      out_tx_r;
  logic [11:0]      out_ty_r;
  logic [OFF_W-1:0] out_off_r;
  logic [7:0]       out_red_r;
  logic [7:0]       out_green_r;
  logic [7:0]       out_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= f2_vld_r;
    end
    out_use_r <= f2_side_r.use_tex;
    if (f2_side_r.use_tex) begin
      out_sel_r   <= f2_side_r.sel;
      out_tx_r    <= 12'(f2_tx_r);
      out_ty_r    <= 12'(f2_ty_r);
      out_off_r   <= off_nxt;
      out_red_r   <= '0;
      out_green_r <= '0;
      out_blue_r  <= '0;
    end else begin
      out_sel_r   <= '0;
      out_tx_r    <= '0;
      out_ty_r    <= '0;
      out_off_r   <= '0;
      out_red_r   <= f2_side_r.red;
      out_green_r <= f2_side_r.green;
      out_blue_r  <= f2_side_r.blue;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_use_texture      = out_use_r;
  assign out_selected_texture = out_sel_r;
  assign out_texel_x          = out_tx_r;
  assign out_texel_y          = out_ty_r;
  assign out_texel_offset     = out_off_r;
  assign out_color_red        = out_red_r;
  assign out_color_green      = out_green_r;
  assign out_color_blue       = out_blue_r;

endmodule

FILE: design/suv_checker.sv
// port level checks for the spherical texel address unit, bound to the top level
module suv_checker
  import suv_pkg::*;
#(
  parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_use_texture,
  input logic [1:0]  out_selected_texture,
  input logic [11:0] out_texel_x,
  input logic [11:0] out_texel_y,
  input logic [25:0] out_texel_offset,
  input logic [7:0]  out_color_red,
  input logic [7:0]  out_color_green,
  input logic [7:0]  out_color_blue
);

  localparam int LAT = ANGLE_STAGES + 8;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("word lost in pipeline");

  a_textured_no_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_use_texture) |->
      (out_color_red == 8'd0 && out_color_green == 8'd0 && out_color_blue == 8'd0))
    else $error("color on textured word");

  a_fallback_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_use_texture) |->
      (out_selected_texture == 2'd0 && out_texel_x == 12'd0
       && out_texel_y == 12'd0 && out_texel_offset == 26'd0))
    else $error("address on fallback word");

endmodule

bind spherical_uv_texel_address suv_checker #(.ANGLE_STAGES(ANGLE_STAGES)) u_suv_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_use_texture      (out_use_texture),
  .out_selected_texture (out_selected_texture),
  .out_texel_x          (out_texel_x),
  .out_texel_y          (out_texel_y),
  .out_texel_offset     (out_texel_offset),
  .out_color_red        (out_color_red),
  .out_color_green      (out_color_green),
  .out_color_blue       (out_color_blue)
);
